@@ hw/rtl/lskc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lskc_pkg: shared definitions for the size-key LRU cache
// Widths, reset values, status codes and the slot update command.
// ----------------------------------------------------------------------------
package lskc_pkg;

	localparam int LSKC_ENTRIES = 8;

	localparam int SIZE_W   = 16;
	localparam int KEY_W    = 13;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 3;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	// The key is the size in half-point steps: four fraction bits less one.
	localparam int KEY_SHIFT = 3;

	localparam logic [SIZE_W-1:0] SIZE_LO_RST = 16'd64;
	localparam logic [SIZE_W-1:0] SIZE_HI_RST = 16'd4608;

	localparam logic REG_SIZE_LO = 1'b0;
	localparam logic REG_SIZE_HI = 1'b1;

	localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FILL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EVICT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic update;
		logic miss;
	} lskc_cmd_t;

endpackage

@@ hw/rtl/lskc_apb_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lskc_apb_regs: configuration registers
// Holds the minimum and maximum accepted font size behind an APB-style port.
// ----------------------------------------------------------------------------
module lskc_apb_regs
	import lskc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output logic [SIZE_W-1:0] size_lo,
	output logic [SIZE_W-1:0] size_hi
);

	logic [SIZE_W-1:0] size_lo_q;
	logic [SIZE_W-1:0] size_hi_q;
	logic              wr_en;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_lo_q <= SIZE_LO_RST;
			size_hi_q <= SIZE_HI_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SIZE_LO: size_lo_q <= pwdata[SIZE_W-1:0];
				REG_SIZE_HI: size_hi_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SIZE_LO: prdata = {{(APB_DW-SIZE_W){1'b0}}, size_lo_q};
			REG_SIZE_HI: prdata = {{(APB_DW-SIZE_W){1'b0}}, size_hi_q};
			default:     prdata = '0;
		endcase
	end

	assign size_lo = size_lo_q;
	assign size_hi = size_hi_q;

endmodule

@@ hw/rtl/lskc_slot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lskc_slot: one cache slot
// Stores key, valid bit and recency age; compares the key and updates the age.
// ----------------------------------------------------------------------------
module lskc_slot
	import lskc_pkg::*;
#(
	parameter int AGE_W = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lskc_cmd_t        cmd,
	input  logic             target,
	input  logic [AGE_W-1:0] hit_age,
	input  logic [KEY_W-1:0] new_key,
	output logic             match,
	output logic             valid,
	output logic [AGE_W-1:0] age,
	output logic [KEY_W-1:0] key
);

	logic             valid_q;
	logic [AGE_W-1:0] age_q;
	logic [KEY_W-1:0] key_q;

	assign match = valid_q && (key_q == new_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (cmd.update) begin
			if (target) begin
				valid_q <= 1'b1;
				age_q   <= '0;
			end else if (valid_q && (cmd.miss || age_q < hit_age)) begin
				// Ages form a permutation of the valid slots, so this cannot wrap.
				age_q <= age_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && cmd.miss && target) begin
			key_q <= new_key;
		end
	end

	assign valid = valid_q;
	assign age   = age_q;
	assign key   = key_q;

endmodule

@@ hw/rtl/lru_size_key_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_size_key_cache: fully associative LRU cache of font-size keys
// Range-checks a size, derives its half-point key, looks it up and updates LRU.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  request   start, busy, font_size                    in (busy out)
//  result    done, status, slot, size_key, evicted_key out
//  config    psel, penable, pwrite, paddr, pwdata,     in / out
//            prdata, pready
//
// A request word is taken in every cycle; busy is always low. The word is
// registered, looked up against all slots in parallel in the next cycle and
// its result word is held through the cycle after that with done high.
// The slot compare and age update set the cycle.
// Reset empties every slot; the result side cannot stall.
// ----------------------------------------------------------------------------
module lru_size_key_cache
	import lskc_pkg::*;
#(
	parameter int ENTRIES = LSKC_ENTRIES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [SIZE_W-1:0]   font_size,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot,
	output logic [KEY_W-1:0]    size_key,
	output logic [KEY_W-1:0]    evicted_key,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(ENTRIES - 1);

	logic [SIZE_W-1:0] size_lo;
	logic [SIZE_W-1:0] size_hi;

	logic              item_valid_s1;
	logic [SIZE_W-1:0] font_size_s1;

	logic                done_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [SLOT_W-1:0]   slot_s2;
	logic [KEY_W-1:0]    size_key_s2;
	logic [KEY_W-1:0]    evicted_key_s2;

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] valid;
	logic [IDX_W-1:0]   age [ENTRIES];
	logic [KEY_W-1:0]   key [ENTRIES];

	logic [ENTRIES-1:0] hit_oh;
	logic [ENTRIES-1:0] free_oh;
	logic [ENTRIES-1:0] vict_oh;
	logic [ENTRIES-1:0] tgt_oh;
	logic               any_hit;
	logic               any_free;
	logic               in_range;
	logic [KEY_W-1:0]   key_s1;
	logic [IDX_W-1:0]   hit_age;
	logic [KEY_W-1:0]   vict_key;
	logic [IDX_W-1:0]   tgt_idx;
	logic [IDX_W+SLOT_W-1:0] tgt_ext;
	logic [STATUS_W-1:0] status_nx;
	lskc_cmd_t          cmd;

	lskc_apb_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.size_lo  (size_lo),
		.size_hi  (size_hi)
	);

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else begin
			item_valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			font_size_s1 <= font_size;
		end
	end

	assign key_s1   = font_size_s1[SIZE_W-1:KEY_SHIFT];
	assign in_range = (font_size_s1 >= size_lo) && (font_size_s1 <= size_hi);

	for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
		lskc_slot #(
			.AGE_W (IDX_W)
		) u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.target  (tgt_oh[g]),
			.hit_age (hit_age),
			.new_key (key_s1),
			.match   (match[g]),
			.valid   (valid[g]),
			.age     (age[g]),
			.key     (key[g])
		);
	end

	// Lowest-numbered slot wins each selection. When the cache is full the ages
	// are a permutation, so the least recent slot is the one at the top age.
	always_comb begin
		logic hit_seen;
		logic free_seen;
		logic vict_seen;
		hit_seen  = 1'b0;
		free_seen = 1'b0;
		vict_seen = 1'b0;
		hit_oh    = '0;
		free_oh   = '0;
		vict_oh   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_oh[i]  = match[i] && !hit_seen;
			free_oh[i] = !valid[i] && !free_seen;
			vict_oh[i] = (age[i] == AGE_MAX) && !vict_seen;
			hit_seen   = hit_seen || match[i];
			free_seen  = free_seen || !valid[i];
			vict_seen  = vict_seen || (age[i] == AGE_MAX);
		end
	end

	assign any_hit  = |match;
	assign any_free = |(~valid);

	always_comb begin
		if (any_hit) begin
			tgt_oh = hit_oh;
		end else if (any_free) begin
			tgt_oh = free_oh;
		end else begin
			tgt_oh = vict_oh;
		end
	end

	always_comb begin
		hit_age  = '0;
		vict_key = '0;
		tgt_idx  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_age  = hit_age | (hit_oh[i] ? age[i] : '0);
			vict_key = vict_key | (vict_oh[i] ? key[i] : '0);
			tgt_idx  = tgt_idx | (tgt_oh[i] ? IDX_W'(i) : '0);
		end
	end

	assign cmd = '{update: item_valid_s1 && in_range, miss: !any_hit};

	always_comb begin
		if (!in_range) begin
			status_nx = ST_RANGE;
		end else if (any_hit) begin
			status_nx = ST_HIT;
		end else if (any_free) begin
			status_nx = ST_FILL;
		end else begin
			status_nx = ST_EVICT;
		end
	end

	assign tgt_ext = {{SLOT_W{1'b0}}, tgt_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= item_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid_s1) begin
			status_s2      <= status_nx;
			size_key_s2    <= key_s1;
			slot_s2        <= in_range ? tgt_ext[SLOT_W-1:0] : '0;
			evicted_key_s2 <= (status_nx == ST_EVICT) ? vict_key : '0;
		end
	end

	assign done        = done_s2;
	assign status      = status_s2;
	assign slot        = slot_s2;
	assign size_key    = size_key_s2;
	assign evicted_key = evicted_key_s2;

endmodule
